// ===== sv/msst_pkg.sv =====
// shared types, constants and helpers for the timer slot table
// used by msst_cell and multi_slot_software_timer_table; no dependencies
package msst_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int SLOT_W = 4;
    localparam int CMP_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    typedef enum logic [1:0] {
        MODE_ADD     = 2'd0,
        MODE_CLEAR   = 2'd1,
        MODE_SERVICE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        KIND_ADDED   = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_CLEARED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_DONE    = 3'd4
    } t_kind;

    typedef struct packed {
        t_mode              mode;
        logic [31:0]        now_ms;
        logic [31:0]        interval_ms;
        logic               periodic;
        logic [SLOT_W-1:0]  slot_id;
    } t_cmd;

    typedef struct packed {
        t_kind              kind;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } t_res;

    // transaction token walking the cell row
    typedef struct packed {
        logic               valid;
        t_cmd               cmd;
        logic               hit;   // add: a slot was claimed upstream
        logic               fire;  // service: the cell just passed fired
        logic [SLOT_W-1:0]  slot;
    } t_tok;

    // slot number as reported, modulo 16
    function automatic logic [SLOT_W-1:0] slot_code(input logic [IDX_W-1:0] idx);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(idx);
        return ext[SLOT_W-1:0];
    endfunction

    function automatic logic id_match(input logic [SLOT_W-1:0] sid,
                                      input logic [IDX_W-1:0] idx);
        return CMP_W'(sid) == CMP_W'(idx);
    endfunction

endpackage

// ===== sv/msst_cell.sv =====
// one timer slot: holds its state and passes the token on to the next cell
// depends on msst_pkg
module msst_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [msst_pkg::IDX_W-1:0]  i_idx,
    input  msst_pkg::t_tok              i_tok,
    output msst_pkg::t_tok              o_tok
);

    logic           r_active, n_active;
    logic [31:0]    r_start, n_start;
    logic [31:0]    r_period, n_period;
    logic           r_repeat, n_repeat;
    msst_pkg::t_tok r_tok, n_tok;
    logic [31:0]    elapsed;

    assign elapsed = i_tok.cmd.now_ms - r_start;

    always_comb begin
        n_active = r_active;
        n_start  = r_start;
        n_period = r_period;
        n_repeat = r_repeat;
        n_tok      = i_tok;
        n_tok.fire = 1'b0;
        if (i_tok.valid) begin
            case (i_tok.cmd.mode)
                msst_pkg::MODE_ADD: begin
                    if (!i_tok.hit && !r_active) begin
                        n_active  = 1'b1;
                        n_start   = i_tok.cmd.now_ms;
                        n_period  = i_tok.cmd.interval_ms;
                        n_repeat  = i_tok.cmd.periodic;
                        n_tok.hit  = 1'b1;
                        n_tok.slot = msst_pkg::slot_code(i_idx);
                    end
                end
                msst_pkg::MODE_CLEAR: begin
                    if (msst_pkg::id_match(i_tok.cmd.slot_id, i_idx)) begin
                        n_active = 1'b0;
                    end
                end
                msst_pkg::MODE_SERVICE: begin
                    if (r_active && (elapsed >= r_period)) begin
                        n_tok.fire = 1'b1;
                        n_tok.slot = msst_pkg::slot_code(i_idx);
                        if (r_repeat) begin
                            n_start = i_tok.cmd.now_ms;
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_tok.valid <= n_tok.valid;
        end
        r_start    <= n_start;
        r_period   <= n_period;
        r_repeat   <= n_repeat;
        r_tok.cmd  <= n_tok.cmd;
        r_tok.hit  <= n_tok.hit;
        r_tok.fire <= n_tok.fire;
        r_tok.slot <= n_tok.slot;
    end

    assign o_tok = r_tok;

endmodule

// ===== sv/multi_slot_software_timer_table.sv =====
// timer slot table: a row of TIMER_SLOTS cells, one per slot; depends on msst_pkg, msst_cell
// start is registered into a token that walks the cell row; the closing result is registered
// after the last cell. A new transaction is taken only while busy is low; busy holds while the token
// walks the cell row one cell per cycle and through the closing result
// results are strobed for one cycle, fired ones in slot order; the receiver cannot stall
// reset: synchronous, clears every slot to inactive at once
module multi_slot_software_timer_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  msst_pkg::t_cmd  i_cmd,
    output logic            busy,
    output logic            o_strobe,
    output msst_pkg::t_res  o_res
);

    msst_pkg::t_tok w_tok [0:msst_pkg::TIMER_SLOTS];
    msst_pkg::t_tok r_tok0;
    logic           r_fin_vld;
    msst_pkg::t_tok r_fin_tok;
    logic           fin_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0.valid <= 1'b0;
        end else begin
            r_tok0.valid <= start && !busy;
        end
        r_tok0.cmd  <= i_cmd;
        r_tok0.hit  <= 1'b0;
        r_tok0.fire <= 1'b0;
        r_tok0.slot <= '0;
    end

    assign w_tok[0] = r_tok0;

    for (genvar k = 0; k < msst_pkg::TIMER_SLOTS; k++) begin : g_cell
        msst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (msst_pkg::IDX_W'(k)),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // unused mode walks the row but closes with no result
    assign fin_take = w_tok[msst_pkg::TIMER_SLOTS].valid &&
        (w_tok[msst_pkg::TIMER_SLOTS].cmd.mode == msst_pkg::MODE_ADD ||
         w_tok[msst_pkg::TIMER_SLOTS].cmd.mode == msst_pkg::MODE_CLEAR ||
         w_tok[msst_pkg::TIMER_SLOTS].cmd.mode == msst_pkg::MODE_SERVICE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_vld <= 1'b0;
        end else begin
            r_fin_vld <= fin_take;
        end
        r_fin_tok <= w_tok[msst_pkg::TIMER_SLOTS];
    end

    always_comb begin
        busy = r_fin_vld;
        for (int k = 0; k <= msst_pkg::TIMER_SLOTS; k++) begin
            busy = busy | w_tok[k].valid;
        end
    end

    always_comb begin
        o_strobe = 1'b0;
        o_res    = '0;
        for (int k = 1; k <= msst_pkg::TIMER_SLOTS; k++) begin
            if (w_tok[k].valid && w_tok[k].fire) begin
                o_strobe   = 1'b1;
                o_res.kind = msst_pkg::KIND_FIRED;
                o_res.slot = w_tok[k].slot;
                o_res.last = 1'b0;
            end
        end
        if (r_fin_vld) begin
            o_strobe   = 1'b1;
            o_res.last = 1'b1;
            case (r_fin_tok.cmd.mode)
                msst_pkg::MODE_ADD: begin
                    if (r_fin_tok.hit) begin
                        o_res.kind = msst_pkg::KIND_ADDED;
                        o_res.slot = r_fin_tok.slot;
                    end else begin
                        o_res.kind = msst_pkg::KIND_FULL;
                        o_res.slot = '0;
                    end
                end
                msst_pkg::MODE_CLEAR: begin
                    o_res.kind = msst_pkg::KIND_CLEARED;
                    o_res.slot = r_fin_tok.cmd.slot_id;
                end
                default: begin
                    o_res.kind = msst_pkg::KIND_DONE;
                    o_res.slot = '0;
                end
            endcase
        end
    end

    logic [msst_pkg::TIMER_SLOTS+1:0] tok_vld_vec;

    always_comb begin
        tok_vld_vec[msst_pkg::TIMER_SLOTS+1] = r_fin_vld;
        for (int k = 0; k <= msst_pkg::TIMER_SLOTS; k++) begin
            tok_vld_vec[k] = w_tok[k].valid;
        end
    end

    // only one transaction is ever in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vld_vec))
        else $error("more than one token in the cell row");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction not tracked as busy");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_res.last |=> !busy)
        else $error("block still busy after final result");

    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_vld |-> !(w_tok[msst_pkg::TIMER_SLOTS].valid && w_tok[msst_pkg::TIMER_SLOTS].fire))
        else $error("fired result collides with closing result");

endmodule
